// ===== hw/rtl/stwf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_pkg: shared constants and functions of the sine tone generator
// Register indexes, port widths and the quarter-wave sine builder that the
// back end uses at elaboration to lay out its lookup ROM.
// ----------------------------------------------------------------------------
package stwf_pkg;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 2'd1;

  // Register widths and reset values.
  localparam int RAMP_W = 17;
  localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 32'd85704564;
  localparam logic [RAMP_W-1:0]     RAMP_STEP_RST  = 17'd15;

  // Sample and table magnitude widths.
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;

  // Pi in Q30 and the peak amplitude of the table.
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] AMPLITUDE = 64'd32000;

  // Unsigned 64-bit quotient, one restoring shift-and-subtract step per bit.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rmd;
    quo = 64'd0;
    rmd = 65'd0;
    for (int b = 63; b >= 0; b--) begin
      rmd = {rmd[63:0], num[b]};
      if (rmd >= {1'b0, dvs}) begin
        rmd    = rmd - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine magnitude for entry j of a table of 2^tbits entries.
  // The Taylor series of sin x is summed in Q30 with each term truncated and
  // stops at the first term that comes out zero.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j,
                                                   input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] den;
    bit          done;
    x    = (PI_Q30 * 64'd2 * 64'(j) + (64'd1 << (tbits - 1))) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    done = 1'b0;
    for (int k = 1; k <= 16; k++) begin
      if (!done) begin
        den  = 64'((2 * k) * (2 * k + 1));
        term = udiv64((term * x2) >> 30, den);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (k[0] == 1'b1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    s = (pos > neg) ? (pos - neg) : 64'd0;
    r = (s * AMPLITUDE + (64'd1 << 29)) >> 30;
    return r[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stwf_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_in_if: tick channel
// Carries one mute flag per sample tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stwf_in_if;
  logic valid;
  logic ready;
  logic mute;

  modport source (output valid, output mute, input ready);
  modport sink   (input valid, input mute, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/stwf_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_out_if: sample channel
// Carries one signed audio sample per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stwf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/stwf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_front: phase accumulator and volume envelope
// Takes tick words, steps the fade envelope, picks the quarter-wave table
// address and sign from the phase, and pushes the job into the queue.
// ----------------------------------------------------------------------------
module stwf_front #(
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_BITS      = 10,
  parameter int VOLUME_FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [stwf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [stwf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  stwf_in_if.sink                          in_ch,
  output logic                             push_valid,
  input  logic                             push_ready,
  output logic [SINE_TABLE_BITS+VOLUME_FRACTION_BITS:0] push_data
);
  import stwf_pkg::*;

  localparam int VW = VOLUME_FRACTION_BITS + 1;
  localparam int CW = ((VW > RAMP_W) ? VW : RAMP_W) + 1;
  localparam int AW = SINE_TABLE_BITS - 1;
  localparam int RW = SINE_TABLE_BITS - 2;
  localparam logic [CW-1:0] FULL = CW'(1) << VOLUME_FRACTION_BITS;
  localparam logic [RW:0]   QUARTER = (RW+1)'(1) << RW;

  logic [CFG_DATA_W-1:0]      phase_step_r;
  logic [RAMP_W-1:0]          ramp_step_r;
  logic [PHASE_BITS-1:0]      phase_r;
  logic [PHASE_BITS-1:0]      phase_nxt;
  logic [VW-1:0]              volume_r;
  logic [VW-1:0]              volume_nxt;
  logic [CW-1:0]              vol_e;
  logic [CW-1:0]              ramp_e;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [RW-1:0]              rem;
  logic [AW-1:0]              addr;
  logic                       neg;
  logic                       accept;

  // Handshake passes straight through to the queue.
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // Fade envelope, clamped to silence and to full scale.
  always_comb begin
    vol_e  = CW'(volume_r);
    ramp_e = CW'(ramp_step_r);
    if (in_ch.mute) begin
      volume_nxt = (vol_e > ramp_e) ? VW'(vol_e - ramp_e) : '0;
    end else begin
      volume_nxt = ((FULL - vol_e) > ramp_e) ? VW'(vol_e + ramp_e) : VW'(FULL);
    end
  end

  // Quarter-wave folding of the table index taken from the current phase.
  always_comb begin
    idx  = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
    rem  = idx[RW-1:0];
    neg  = idx[SINE_TABLE_BITS-1];
    if (idx[SINE_TABLE_BITS-2]) begin
      addr = AW'(QUARTER - (RW+1)'(rem));
    end else begin
      addr = AW'(rem);
    end
    phase_nxt = phase_r + PHASE_BITS'(phase_step_r);
  end

  assign push_data = {addr, neg, volume_nxt};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      ramp_step_r  <= RAMP_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PHASE_STEP: phase_step_r <= cfg_wdata;
        REG_RAMP_STEP:  ramp_step_r  <= cfg_wdata[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Oscillator state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      volume_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      volume_r <= volume_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stwf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_queue: two-entry job queue
// Decouples the oscillator front end from the multiply back end so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module stwf_queue #(
  parameter int WIDTH = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import stwf_pkg::*;

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stwf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_back: table lookup, volume multiply and output register
// Three elastic stages: registered ROM read, registered product, and the
// output word with its sign restored.
// ----------------------------------------------------------------------------
module stwf_back #(
  parameter int SINE_TABLE_BITS      = 10,
  parameter int VOLUME_FRACTION_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       pop_valid,
  output logic                                       pop_ready,
  input  logic [SINE_TABLE_BITS+VOLUME_FRACTION_BITS:0] pop_data,
  stwf_out_if.source                                 out_ch
);
  import stwf_pkg::*;

  localparam int VW = VOLUME_FRACTION_BITS + 1;
  localparam int AW = SINE_TABLE_BITS - 1;
  localparam int QN = 1 << (SINE_TABLE_BITS - 2);
  localparam int PW = MAG_W + VW;

  typedef logic [MAG_W-1:0] qtab_t [QN+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int j = 0; j <= QN; j++) begin
      t[j] = quarter_sine(j, SINE_TABLE_BITS);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [AW-1:0]       job_addr;
  logic                job_neg;
  logic [VW-1:0]       job_vol;

  logic                a_valid_r;
  logic [MAG_W-1:0]    rom_q_r;
  logic                a_neg_r;
  logic [VW-1:0]       a_vol_r;
  logic                b_valid_r;
  logic [PW-1:0]       prod_r;
  logic                b_neg_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] mag;

  logic                c_take;
  logic                b_take;
  logic                a_take;

  assign {job_addr, job_neg, job_vol} = pop_data;

  // Stage advance: a stage loads when it is empty or its word moves on.
  assign c_take    = b_valid_r && (!out_valid_r || out_ch.ready);
  assign b_take    = a_valid_r && (!b_valid_r || c_take);
  assign a_take    = pop_valid && (!a_valid_r || b_take);
  assign pop_ready = !a_valid_r || b_take;

  assign mag = prod_r[VOLUME_FRACTION_BITS +: SAMPLE_W];

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_r <= 1'b1;
      end else if (b_take) begin
        a_valid_r <= 1'b0;
      end
      if (b_take) begin
        b_valid_r <= 1'b1;
      end else if (c_take) begin
        b_valid_r <= 1'b0;
      end
      if (c_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Quarter-wave ROM read.
  always_ff @(posedge clk) begin
    if (a_take) begin
      rom_q_r <= QTAB[job_addr];
      a_neg_r <= job_neg;
      a_vol_r <= job_vol;
    end
  end

  // Magnitude times volume.
  always_ff @(posedge clk) begin
    if (b_take) begin
      prod_r  <= PW'(rom_q_r) * PW'(a_vol_r);
      b_neg_r <= a_neg_r;
    end
  end

  // Drop the volume fraction and restore the sign; this truncates toward zero.
  always_ff @(posedge clk) begin
    if (c_take) begin
      sample_r <= b_neg_r ? (SAMPLE_W'(0) - mag) : mag;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sine_tone_with_fade_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sine_tone_with_fade_core: sine tone generator with linear fade
// Direct digital synthesis of a sine tone whose volume ramps toward silence
// or full scale under control of each tick's mute flag.
// ----------------------------------------------------------------------------
//  channel  | direction | word contents
//  in_ch    | sink      | mute (1 bit): fade toward zero when set
//  out_ch   | source    | sample (16 bit signed): sine times volume
//  cfg_*    | write     | index 0 phase_step, index 1 ramp_step
//
// One tick word is taken per clock while out_ch does not stall; throughput
// is set by the single multiplier stage of the back end, which accepts a new
// job every cycle unless the output stage is held. A sample goes from its tick
// through the queue, ROM read, multiply and output register. Reset is
// synchronous and needs no clearing pass. A stall on out_ch fills the back
// stages and then the two-entry queue before in_ch.ready drops.
// ----------------------------------------------------------------------------
module sine_tone_with_fade_core #(
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_BITS      = 10,
  parameter int VOLUME_FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [stwf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [stwf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  stwf_in_if.sink                         in_ch,
  stwf_out_if.source                      out_ch
);
  import stwf_pkg::*;

  localparam int EW = SINE_TABLE_BITS + VOLUME_FRACTION_BITS + 1;

  logic          fq_valid;
  logic          fq_ready;
  logic [EW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [EW-1:0] qb_data;

  stwf_front #(
    .PHASE_BITS           (PHASE_BITS),
    .SINE_TABLE_BITS      (SINE_TABLE_BITS),
    .VOLUME_FRACTION_BITS (VOLUME_FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data)
  );

  stwf_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  stwf_back #(
    .SINE_TABLE_BITS      (SINE_TABLE_BITS),
    .VOLUME_FRACTION_BITS (VOLUME_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // A delivered sample never exceeds the table amplitude.
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.sample <= 16'sd32000 && out_ch.sample >= -16'sd32000))
    else $error("sample outside the table amplitude");

  // Reset empties the back end.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output word present after reset");

  // A queued job waits at the head until the back end takes it.
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (qb_valid && !qb_ready) |=> (qb_valid && $stable(qb_data)))
    else $error("queue head changed while the back end stalled");
`endif

endmodule
`default_nettype wire

// ===== bench/stwf_sample_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stwf_sample_checker: sample predictor and scoreboard for the tone core
// Watches the tick, sample and configuration ports. It keeps its own copy of
// the phase accumulator, the volume envelope and the sine ROM, predicts one
// sample per accepted tick word and compares each sample word against the
// oldest prediction.
// ----------------------------------------------------------------------------
module stwf_sample_checker
  import stwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  stwf_in_if                    tick_mon,
  stwf_out_if                   sample_mon,
  output int unsigned           mismatch_count,
  output int unsigned           pending
);

  localparam int          ROM_BITS      = 10;
  localparam int          ROM_DEPTH     = 1 << ROM_BITS;
  localparam int          QUARTER       = ROM_DEPTH / 4;
  localparam int          VOL_FRAC      = 16;
  localparam logic [16:0] VOL_FULL      = 17'h1_0000;
  localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
  localparam logic [63:0] PEAK          = 64'd32000;

  logic signed [15:0] sine_rom [ROM_DEPTH];
  logic [31:0]        phase_acc;
  logic [31:0]        phase_inc;
  logic [16:0]        vol_level;
  logic [16:0]        vol_ramp;
  logic signed [15:0] expected_samples [$];

  // First-quadrant magnitude: Taylor series of sin in Q30, each term
  // truncated, stopping at the first term that rounds down to zero.
  function automatic logic [15:0] quarter_wave_mag(input int unsigned j);
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] term;
    logic [63:0] plus_sum;
    logic [63:0] minus_sum;
    logic [63:0] net;
    angle     = (HALF_TURN_Q30 * 64'd2 * 64'(j) + 64'(ROM_DEPTH / 2)) >> ROM_BITS;
    angle_sq  = (angle * angle) >> 30;
    term      = angle;
    plus_sum  = angle;
    minus_sum = 64'd0;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (term == 64'd0) break;
      if (k % 2 == 1) begin
        minus_sum = minus_sum + term;
      end else begin
        plus_sum = plus_sum + term;
      end
    end
    net = (plus_sum > minus_sum) ? plus_sum - minus_sum : 64'd0;
    return 16'((net * PEAK + (64'd1 << 29)) >> 30);
  endfunction

  // The remaining quadrants mirror and negate the first one.
  initial begin
    logic [15:0] mag;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if ((i / QUARTER) % 2 == 1) begin
        mag = quarter_wave_mag(QUARTER - i % QUARTER);
      end else begin
        mag = quarter_wave_mag(i % QUARTER);
      end
      sine_rom[i] = (i / QUARTER >= 2) ? -$signed(mag) : $signed(mag);
    end
  end

  // Moves the envelope, scales the current table entry and steps the phase.
  function automatic logic signed [15:0] fade_and_look_up(input logic mute);
    logic signed [15:0] tone;
    int unsigned        mag_abs;
    int unsigned        scaled;
    logic signed [15:0] result_word;
    if (mute) begin
      vol_level = (vol_level > vol_ramp) ? vol_level - vol_ramp : 17'd0;
    end else begin
      vol_level = ((VOL_FULL - vol_level) > vol_ramp) ? vol_level + vol_ramp : VOL_FULL;
    end
    tone        = sine_rom[phase_acc[31:32-ROM_BITS]];
    mag_abs     = (tone < 0) ? 32'(-tone) : 32'(tone);
    scaled      = (mag_abs * 32'(vol_level)) >> VOL_FRAC;
    result_word = 16'(scaled);
    if (tone < 0) result_word = -result_word;
    phase_acc = phase_acc + phase_inc;
    return result_word;
  endfunction

  // Register writes, sample comparison and tick prediction, all sampled at
  // the rising edge. A sample word is checked before the tick of the same
  // edge is predicted, so a sample can never match its own tick.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      phase_acc = 32'd0;
      vol_level = 17'd0;
      phase_inc = PHASE_STEP_RST;
      vol_ramp  = RAMP_STEP_RST;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PHASE_STEP: phase_inc = cfg_wdata;
          REG_RAMP_STEP:  vol_ramp  = cfg_wdata[RAMP_W-1:0];
          default: ;
        endcase
      end
      if (sample_mon.valid && sample_mon.ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          $error("sample word with no tick waiting: actual %0d", sample_mon.sample);
        end else begin
          want = expected_samples.pop_front();
          if (sample_mon.sample !== want) begin
            mismatch_count++;
            $error("sample mismatch: expected %0d, actual %0d", want, sample_mon.sample);
          end
        end
      end
      if (tick_mon.valid && tick_mon.ready) begin
        expected_samples.push_back(fade_and_look_up(tick_mon.mute));
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== bench/sine_tone_with_fade_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_tone_with_fade_core_test: top-level bench of the sine tone core
// Drives tick words and register writes, stalls the sample channel at
// random, and leaves prediction and comparison to the sample checker.
// A short directed part covers the output extremes, clamping of the fade,
// phase wrap and ignored register indexes; random phases follow, each with
// its own register settings and idle pattern.
// ----------------------------------------------------------------------------
module sine_tone_with_fade_core_test;
  import stwf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int RESET_CYCLES    = 7;
  localparam int TICK_TARGET     = 1750;
  localparam int CLOSING_TICKS   = 150;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PRESSURE_PHASE  = 2;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 500000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatch_count;
  int unsigned           pending;
  int unsigned           cycle_count;
  int unsigned           ticks_sent;
  int unsigned           send_idle_odds;
  int unsigned           recv_idle_odds;
  bit                    hold_off_req;

  stwf_in_if  tick_ch ();
  stwf_out_if sample_ch ();

  sine_tone_with_fade_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (tick_ch),
    .out_ch    (sample_ch)
  );

  stwf_sample_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .tick_mon       (tick_ch),
    .sample_mon     (sample_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sample receiver: random stall bursts, or one long hold-off on request
  // so that the core backs up into its tick input.
  initial begin
    sample_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        sample_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        sample_ch.ready <= 1'b1;
      end else if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1) begin
        sample_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        sample_ch.ready <= 1'b1;
      end else begin
        sample_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one tick word, possibly after an idle burst, and returns at the
  // edge where it is taken.
  task automatic send_tick(input logic mute_bit);
    if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.mute  <= mute_bit;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every predicted sample has come.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned remaining;
    int unsigned run_len;
    int unsigned phase_no;
    logic        mute_bit;
    logic [31:0] step_word;
    logic [16:0] ramp_val;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_PHASE_STEP;
    cfg_wdata     <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.mute  <= 1'b0;
    hold_off_req   = 1'b0;
    send_idle_odds = 4;
    recv_idle_odds = 4;
    ticks_sent     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Quarter-turn steps visit zero, peak and trough; a ramp wider than full
    // scale clamps the envelope on the first tick in either direction.
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_RAMP_STEP, 32'h0001_FFFF);
    repeat (4) send_tick(1'b0);
    repeat (2) send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Phase wraps on every tick and the ramp equals exactly full scale.
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RAMP_STEP, 32'h0001_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Reset-rate tone with junk above the ramp field, then writes to unused
    // indexes that must leave both registers alone. The small ramp reaches
    // the silent bound exactly on the way down.
    write_reg(REG_PHASE_STEP, PHASE_STEP_RST);
    write_reg(REG_RAMP_STEP, 32'hFFFE_000F);
    write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_3, 32'h0000_0001);
    repeat (3) send_tick(1'b0);
    repeat (4) send_tick(1'b1);

    // Random phases: fresh registers, idle pattern and mute runs each time.
    phase_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      drain();
      case ($urandom_range(0, 5))
        0:       step_word = 32'd0;
        1:       step_word = 32'h8000_0000;
        2:       step_word = 32'hFFFF_FFFF;
        3:       step_word = $urandom;
        4:       step_word = $urandom_range(1, 32'h0100_0000);
        default: step_word = $urandom_range(1000000, 200000000);
      endcase
      case ($urandom_range(0, 6))
        0:       ramp_val = 17'd0;
        1:       ramp_val = 17'd1;
        2:       ramp_val = 17'h1_0000;
        3:       ramp_val = 17'h1_FFFF;
        4:       ramp_val = 17'($urandom_range(1, 64));
        5:       ramp_val = 17'($urandom_range(100, 4000));
        default: ramp_val = 17'($urandom_range(0, 17'h1_FFFF));
      endcase
      write_reg(REG_PHASE_STEP, step_word);
      write_reg(REG_RAMP_STEP, ($urandom & 32'hFFFE_0000) | 32'(ramp_val));

      if (ticks_sent + CLOSING_TICKS >= TICK_TARGET) begin
        send_idle_odds = 0;
        recv_idle_odds = 0;
        remaining      = CLOSING_TICKS;
      end else begin
        case ($urandom_range(0, 3))
          0:       send_idle_odds = 0;
          1:       send_idle_odds = 3;
          2:       send_idle_odds = 8;
          default: send_idle_odds = 20;
        endcase
        case ($urandom_range(0, 3))
          0:       recv_idle_odds = 0;
          1:       recv_idle_odds = 3;
          2:       recv_idle_odds = 8;
          default: recv_idle_odds = 20;
        endcase
        remaining = $urandom_range(40, 200);
      end

      // One phase keeps offering ticks while the receiver holds off.
      if (phase_no == PRESSURE_PHASE) begin
        hold_off_req   = 1'b1;
        send_idle_odds = 0;
      end

      while (remaining > 0) begin
        run_len  = $urandom_range(1, 60);
        if (run_len > remaining) run_len = remaining;
        mute_bit = 1'($urandom_range(0, 1));
        repeat (run_len) send_tick(mute_bit);
        remaining = remaining - run_len;
      end
      phase_no++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
